### rtl/dtt_pkg.sv
// Package for the deadline timer table: operation and status codes, field widths,
// and the FSM state type.
// No dependencies.
package dtt_pkg;
  localparam int NumTimersDef = 16;
  localparam int TimeW = 48;
  localparam int PerW = 32;
  localparam int SlotW = 4;
  localparam int MaxRes = 16;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_CANCEL = 3'd1;
  localparam logic [2:0] FN_REFRESH = 3'd2;
  localparam logic [2:0] FN_RESET = 3'd3;
  localparam logic [2:0] FN_EXPIRE = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_INACTIVE = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_OP, S_XSCAN, S_XUPD, S_FSCAN, S_EMIT, S_WAIT
  } state_t;
endpackage

### rtl/dtt_ram.sv
// Generic single-port-write, one-read synchronous RAM with a registered read.
// No dependencies.
module dtt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/deadline_timer_table_unit.sv
// Deadline timer table: top level. Timer state lives in one RAM (deadline, period,
// repeat) with active bits in flip-flops. Uses dtt_pkg and dtt_ram.
// Add, cancel, refresh and reset do a RAM read, op and write, a front scan over all slots
// and an emit. Expire does one pick pass per due timer (at most MaxRes) plus a final pass,
// an update pass and a front scan, then emits a beat per picked timer (or one if none).
// One item at a time, next accept the cycle after the last beat. Reset clears active bits.
module deadline_timer_table_unit #(
  parameter int NumTimers = dtt_pkg::NumTimersDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // func[2:0], slot_id[6:3], interval_ms[38:7], periodic[39], from_now[40],
  // now_ms[88:41], zero fill to 96
  input  logic [95:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], result_slot[5:2], fired[6], front_changed[7],
  // first_deadline[55:8], any_active[56], zero fill to 64
  output logic [63:0]  out_tdata,
  output logic         out_tlast
);
  localparam int AW = $clog2(NumTimers);
  localparam int EW = dtt_pkg::TimeW + dtt_pkg::PerW + 1;
  localparam int CW = $clog2(NumTimers + 1);
  localparam int RcW = $clog2(dtt_pkg::MaxRes + 1);

  dtt_pkg::state_t st_r, st_nxt;

  logic [2:0] func_r;
  logic [dtt_pkg::SlotW-1:0] sid_r;
  logic [dtt_pkg::PerW-1:0] iv_r;
  logic per_r, fn_r;
  logic [dtt_pkg::TimeW-1:0] now_r;

  logic [NumTimers-1:0] act_r, act_nxt, taken_r, taken_nxt;
  logic [AW-1:0] tgt_r, tgt_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [RcW-1:0] nres_r, nres_nxt;
  logic [AW-1:0] ord_r [dtt_pkg::MaxRes];
  logic [AW-1:0] ord_nxt [dtt_pkg::MaxRes];
  logic [RcW-1:0] emit_r, emit_nxt;

  logic bvalid_r, bvalid_nxt;
  logic [AW-1:0] bslot_r, bslot_nxt;
  logic [dtt_pkg::TimeW-1:0] bdl_r, bdl_nxt;
  logic brep_r, brep_nxt;
  logic rvalid_r, rvalid_nxt;
  logic [AW-1:0] rslot_r, rslot_nxt;

  logic [1:0] stat_r, stat_nxt;
  logic [AW-1:0] res_slot_r, res_slot_nxt;
  logic fc_r, fc_nxt;

  logic ovalid_r, ovalid_nxt;
  logic [63:0] odata_r, odata_nxt;
  logic olast_r, olast_nxt;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [dtt_pkg::TimeW-1:0] rd_dl;
  logic [dtt_pkg::PerW-1:0] rd_per;
  logic rd_rep;

  dtt_ram #(.Width(EW), .Depth(NumTimers)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );
  assign {rd_rep, rd_per, rd_dl} = rdata;

  function automatic logic [dtt_pkg::TimeW-1:0] sat_add(
    input logic [dtt_pkg::TimeW-1:0] a, input logic [dtt_pkg::TimeW-1:0] b);
    logic [dtt_pkg::TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[dtt_pkg::TimeW] ? dtt_pkg::TimeMax : s[dtt_pkg::TimeW-1:0];
  endfunction

  logic sid_ok, sid_valid, has_free;
  logic [AW-1:0] free_slot, cnt_a, rcnt_a;
  logic [dtt_pkg::TimeW-1:0] per48, iv48, start, newdl;
  logic scan_done;

  always_comb begin
    free_slot = '0;
    has_free = 1'b0;
    for (int i = NumTimers - 1; i >= 0; i--) begin
      if (!act_r[i]) begin
        free_slot = AW'(i);
        has_free = 1'b1;
      end
    end
  end

  assign sid_ok = (32'(sid_r) < NumTimers);
  assign sid_valid = sid_ok && act_r[sid_r[AW-1:0]];
  assign per48 = dtt_pkg::TimeW'(rd_per);
  assign iv48 = dtt_pkg::TimeW'(iv_r);
  assign start = fn_r ? now_r : ((rd_dl >= per48) ? (rd_dl - per48) : '0);
  assign cnt_a = cnt_r[AW-1:0];
  assign rcnt_a = rslot_r;
  assign scan_done = (cnt_r == CW'(NumTimers));

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      dtt_pkg::S_IDLE: if (in_tvalid) st_nxt = dtt_pkg::S_RD;
      dtt_pkg::S_RD: st_nxt = dtt_pkg::S_OP;
      dtt_pkg::S_OP: begin
        if (func_r == dtt_pkg::FN_EXPIRE) st_nxt = dtt_pkg::S_XSCAN;
        else st_nxt = dtt_pkg::S_FSCAN;
      end
      dtt_pkg::S_XSCAN: begin
        if (scan_done && !rvalid_r) begin
          if (!bvalid_r || nres_r == RcW'(dtt_pkg::MaxRes)) st_nxt = dtt_pkg::S_XUPD;
        end
      end
      dtt_pkg::S_XUPD: if (scan_done && !rvalid_r) st_nxt = dtt_pkg::S_FSCAN;
      dtt_pkg::S_FSCAN: if (scan_done && !rvalid_r) st_nxt = dtt_pkg::S_EMIT;
      dtt_pkg::S_EMIT: st_nxt = dtt_pkg::S_WAIT;
      dtt_pkg::S_WAIT: begin
        if (!ovalid_r || out_tready) begin
          if (olast_r) st_nxt = dtt_pkg::S_IDLE;
          else st_nxt = dtt_pkg::S_EMIT;
        end
      end
      default: st_nxt = dtt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    act_nxt = act_r;
    taken_nxt = taken_r;
    tgt_nxt = tgt_r;
    cnt_nxt = cnt_r;
    nres_nxt = nres_r;
    ord_nxt = ord_r;
    emit_nxt = emit_r;
    bvalid_nxt = bvalid_r;
    bslot_nxt = bslot_r;
    bdl_nxt = bdl_r;
    brep_nxt = brep_r;
    rvalid_nxt = 1'b0;
    rslot_nxt = rslot_r;
    stat_nxt = stat_r;
    res_slot_nxt = res_slot_r;
    fc_nxt = fc_r;
    ovalid_nxt = ovalid_r;
    odata_nxt = odata_r;
    olast_nxt = olast_r;
    we = 1'b0;
    waddr = tgt_r;
    wdata = {brep_r, iv_r, bdl_r};
    raddr = sid_r[AW-1:0];
    newdl = '0;
    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;
    case (st_r)
      dtt_pkg::S_IDLE: begin
        taken_nxt = '0;
        nres_nxt = '0;
        emit_nxt = '0;
        stat_nxt = dtt_pkg::ST_OK;
        res_slot_nxt = '0;
        fc_nxt = 1'b0;
        tgt_nxt = sid_r[AW-1:0];
      end
      dtt_pkg::S_RD: tgt_nxt = sid_r[AW-1:0];
      dtt_pkg::S_OP: begin
        cnt_nxt = '0;
        bvalid_nxt = 1'b0;
        case (func_r)
          dtt_pkg::FN_ADD: begin
            if (has_free) begin
              we = 1'b1;
              waddr = free_slot;
              wdata = {per_r, iv_r, sat_add(now_r, iv48)};
              act_nxt[free_slot] = 1'b1;
              res_slot_nxt = free_slot;
              tgt_nxt = free_slot;
              fc_nxt = 1'b1;
            end else begin
              stat_nxt = dtt_pkg::ST_FULL;
            end
          end
          dtt_pkg::FN_CANCEL: begin
            if (sid_valid) act_nxt[sid_r[AW-1:0]] = 1'b0;
            else stat_nxt = dtt_pkg::ST_INACTIVE;
          end
          dtt_pkg::FN_REFRESH: begin
            if (sid_valid) begin
              we = 1'b1;
              waddr = sid_r[AW-1:0];
              wdata = {rd_rep, rd_per, sat_add(now_r, per48)};
              fc_nxt = 1'b1;
            end else stat_nxt = dtt_pkg::ST_INACTIVE;
          end
          dtt_pkg::FN_RESET: begin
            if (sid_valid) begin
              we = 1'b1;
              waddr = sid_r[AW-1:0];
              wdata = {rd_rep, iv_r, sat_add(start, iv48)};
              fc_nxt = 1'b1;
            end else stat_nxt = dtt_pkg::ST_INACTIVE;
          end
          default: ;
        endcase
      end
      dtt_pkg::S_XSCAN: begin
        // one pick per pass over all slots
        if (!scan_done) begin
          raddr = cnt_a;
          rvalid_nxt = 1'b1;
          rslot_nxt = cnt_a;
          cnt_nxt = cnt_r + 1'b1;
        end
        if (rvalid_r && act_r[rcnt_a] && !taken_r[rcnt_a] && rd_dl <= now_r
            && (!bvalid_r || rd_dl < bdl_r)) begin
          bvalid_nxt = 1'b1;
          bslot_nxt = rcnt_a;
          bdl_nxt = rd_dl;
        end
        if (scan_done && !rvalid_r) begin
          cnt_nxt = '0;
          bvalid_nxt = 1'b0;
          if (bvalid_r && nres_r != RcW'(dtt_pkg::MaxRes)) begin
            taken_nxt[bslot_r] = 1'b1;
            ord_nxt[nres_r[$clog2(dtt_pkg::MaxRes)-1:0]] = bslot_r;
            nres_nxt = nres_r + 1'b1;
          end
        end
      end
      dtt_pkg::S_XUPD: begin
        if (!scan_done) begin
          raddr = cnt_a;
          rvalid_nxt = 1'b1;
          rslot_nxt = cnt_a;
          cnt_nxt = cnt_r + 1'b1;
        end
        if (rvalid_r && taken_r[rcnt_a]) begin
          if (rd_rep) begin
            we = 1'b1;
            waddr = rcnt_a;
            wdata = {rd_rep, rd_per, sat_add(now_r, per48)};
          end else act_nxt[rcnt_a] = 1'b0;
        end
        if (scan_done && !rvalid_r) begin
          cnt_nxt = '0;
          bvalid_nxt = 1'b0;
        end
      end
      dtt_pkg::S_FSCAN: begin
        if (!scan_done) begin
          raddr = cnt_a;
          rvalid_nxt = 1'b1;
          rslot_nxt = cnt_a;
          cnt_nxt = cnt_r + 1'b1;
        end
        if (rvalid_r && act_r[rcnt_a] && (!bvalid_r || rd_dl < bdl_r)) begin
          bvalid_nxt = 1'b1;
          bslot_nxt = rcnt_a;
          bdl_nxt = rd_dl;
          brep_nxt = rd_rep;
        end
        if (scan_done && !rvalid_r) begin
          if (func_r == dtt_pkg::FN_EXPIRE) begin
            fc_nxt = bvalid_r && taken_r[bslot_r] && brep_r;
          end else begin
            fc_nxt = fc_r && bvalid_r && (bslot_r == tgt_r);
          end
        end
      end
      dtt_pkg::S_EMIT: begin
        newdl = bvalid_r ? bdl_r : dtt_pkg::TimeMax;
        ovalid_nxt = 1'b1;
        if (func_r == dtt_pkg::FN_EXPIRE && nres_r != '0) begin
          odata_nxt = {7'b0, bvalid_r, newdl, fc_r, 1'b1,
                       dtt_pkg::SlotW'(ord_r[emit_r[$clog2(dtt_pkg::MaxRes)-1:0]]),
                       dtt_pkg::ST_OK};
          olast_nxt = (emit_r + 1'b1 == nres_r);
          emit_nxt = emit_r + 1'b1;
        end else begin
          odata_nxt = {7'b0, bvalid_r, newdl, fc_r, 1'b0,
                       dtt_pkg::SlotW'(res_slot_r), stat_r};
          olast_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= dtt_pkg::S_IDLE;
      act_r <= '0;
      ovalid_r <= 1'b0;
      rvalid_r <= 1'b0;
      bvalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      act_r <= act_nxt;
      ovalid_r <= ovalid_nxt;
      rvalid_r <= rvalid_nxt;
      bvalid_r <= bvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == dtt_pkg::S_IDLE && in_tvalid) begin
      func_r <= in_tdata[2:0];
      sid_r <= in_tdata[6:3];
      iv_r <= in_tdata[38:7];
      per_r <= in_tdata[39];
      fn_r <= in_tdata[40];
      now_r <= in_tdata[88:41];
    end
    taken_r <= taken_nxt;
    tgt_r <= tgt_nxt;
    cnt_r <= cnt_nxt;
    nres_r <= nres_nxt;
    ord_r <= ord_nxt;
    emit_r <= emit_nxt;
    bslot_r <= bslot_nxt;
    bdl_r <= bdl_nxt;
    brep_r <= brep_nxt;
    rslot_r <= rslot_nxt;
    stat_r <= stat_nxt;
    res_slot_r <= res_slot_nxt;
    fc_r <= fc_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

  assign in_tready = (st_r == dtt_pkg::S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata = odata_r;
  assign out_tlast = olast_r;

  a_emit_one: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == dtt_pkg::S_EMIT) |=> ovalid_r) else $error("emit lost");
  a_nres_max: assert property (@(posedge clk) disable iff (!rst_n)
    nres_r <= RcW'(dtt_pkg::MaxRes)) else $error("too many results");
  a_fired_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == dtt_pkg::S_XUPD) |-> ($countones(taken_r) == 32'(nres_r)))
    else $error("taken mismatch");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != dtt_pkg::S_IDLE) |-> !in_tready) else $error("ready while busy");
endmodule
